// File: src/transaction_id_bitmap_allocator_macros.svh
// Assertion macros used by the allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TRANSACTION_ID_BITMAP_ALLOCATOR_MACROS_SVH
`define TRANSACTION_ID_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TIBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TIBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tiba_pkg.sv
// Shared types and constants for the transaction id bitmap allocator.
// No dependencies; imported by every module of the block.
package tiba_pkg;

  localparam int ID_W              = 16;
  localparam int SEGMENT_COUNT_DEF = 4096;
  localparam int SEGMENT_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    ACT_PEEK     = 2'd0,
    ACT_ALLOCATE = 2'd1,
    ACT_OCCUPY   = 2'd2,
    ACT_RELEASE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   given_id;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   free_id;
  } rsp_t;

endpackage

// File: src/transaction_id_bitmap_allocator.sv
// Top level of the transaction id bitmap allocator: segment memory, sequencer.
// Depends on tiba_pkg, tiba_div and tiba_ffz.
//
//  channel   ports                      handshake
//  request   start, busy, in_req        taken when start && !busy
//  result    out_valid, out_rsp         one-cycle strobe, always taken
//
// Peek/allocate: the single memory read port checks one segment per cycle;
//   the result strobe comes once a free bit is found or every segment is examined.
// Occupy/release: with power-of-two sizes the id is split by slicing, else by two
//   passes through the reciprocal divider; then a read-modify-write.
// After reset the memory is cleared one segment a cycle, with busy held high
//   until the sweep ends. Results cannot be stalled; one is produced per request.
module transaction_id_bitmap_allocator #(
  parameter int SEGMENT_COUNT = tiba_pkg::SEGMENT_COUNT_DEF,
  parameter int SEGMENT_BITS  = tiba_pkg::SEGMENT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tiba_pkg::req_t in_req,
  output logic          out_valid,
  output tiba_pkg::rsp_t out_rsp
);
  import tiba_pkg::*;

  localparam int SW      = $clog2(SEGMENT_COUNT);
  localparam int BW      = $clog2(SEGMENT_BITS);
  localparam int IDW     = SW + BW;
  localparam int DIV_MAX = (SEGMENT_COUNT > SEGMENT_BITS) ? SEGMENT_COUNT : SEGMENT_BITS;
  localparam int DVW     = $clog2(DIV_MAX + 1);
  localparam bit POW2    = ((SEGMENT_COUNT & (SEGMENT_COUNT - 1)) == 0) &&
                           ((SEGMENT_BITS & (SEGMENT_BITS - 1)) == 0);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_DIV_BIT = 6'b001000,
    ST_DIV_SEG = 6'b010000,
    ST_RMW     = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  action_t            act_r, act_nxt;
  logic [SW-1:0]      seg_r, seg_nxt;       // sweep, scan or target segment
  logic [SW-1:0]      cnt_r, cnt_nxt;       // segments examined minus one
  logic [SW-1:0]      hint_r, hint_nxt;     // segment of the search hint
  logic [BW-1:0]      bit_r, bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  rsp_t               out_rsp_r, out_rsp_nxt;

  logic [SEGMENT_BITS-1:0] mem [SEGMENT_COUNT];
  logic [SEGMENT_BITS-1:0] q_r;
  logic [SW-1:0]           rd_addr;
  logic                    we;
  logic [SEGMENT_BITS-1:0] wd;

  logic [SW-1:0]      seg_inc;
  logic               ffz_any;
  logic [BW-1:0]      ffz_idx;
  logic [IDW-1:0]     found_id;
  logic [BW-1:0]      hint_bit;

  logic                 div_start;
  logic                 div_sel_seg;
  logic [ID_W-1:0]      div_dividend;
  logic                 div_done;
  logic [ID_W-1:0]      div_quot;
  logic [DVW-1:0]       div_rem;

  tiba_ffz #(.W(SEGMENT_BITS)) u_ffz (
    .word     (q_r),
    .any_zero (ffz_any),
    .idx      (ffz_idx)
  );

  tiba_div #(
    .DIV_A (SEGMENT_BITS),
    .DIV_B (SEGMENT_COUNT),
    .DVW   (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sel_b    (div_sel_seg),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign seg_inc  = (seg_r == SW'(SEGMENT_COUNT - 1)) ? '0 : seg_r + SW'(1);
  assign found_id = IDW'(seg_r) * IDW'(SEGMENT_BITS) + IDW'(ffz_idx);
  assign hint_bit = (state_r == ST_SCAN) ? ffz_idx : bit_r;

  // first pass splits off the bit, second reduces the quotient to a segment
  assign div_dividend = (state_r == ST_IDLE) ? in_req.given_id : div_quot;
  assign div_sel_seg  = (state_r == ST_DIV_BIT);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    seg_nxt       = seg_r;
    cnt_nxt       = cnt_r;
    hint_nxt      = hint_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    rd_addr       = seg_r;
    we            = 1'b0;
    wd            = '0;
    div_start     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        seg_nxt = seg_inc;
        if (seg_r == SW'(SEGMENT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          act_nxt = in_req.action;
          if (in_req.action == ACT_PEEK || in_req.action == ACT_ALLOCATE) begin
            rd_addr   = hint_r;
            seg_nxt   = hint_r;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else if (POW2) begin
            // id splits by slicing; truncation wraps ids beyond the space
            rd_addr   = SW'(in_req.given_id >> BW);
            seg_nxt   = SW'(in_req.given_id >> BW);
            bit_nxt   = BW'(in_req.given_id);
            state_nxt = ST_RMW;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV_BIT;
          end
        end
      end

      ST_SCAN: begin
        rd_addr = seg_inc;
        if (ffz_any) begin
          out_valid_nxt       = 1'b1;
          out_rsp_nxt.found   = 1'b1;
          out_rsp_nxt.free_id = ID_W'(found_id);
          if (act_r == ACT_ALLOCATE) begin
            we       = 1'b1;
            wd       = q_r | (SEGMENT_BITS'(1) << ffz_idx);
            hint_nxt = (hint_bit == BW'(SEGMENT_BITS - 1)) ? seg_inc : seg_r;
          end
          state_nxt = ST_IDLE;
        end else if (cnt_r == SW'(SEGMENT_COUNT - 1)) begin
          out_valid_nxt       = 1'b1;
          out_rsp_nxt.found   = 1'b0;
          out_rsp_nxt.free_id = '0;
          state_nxt           = ST_IDLE;
        end else begin
          seg_nxt = seg_inc;
          cnt_nxt = cnt_r + SW'(1);
        end
      end

      ST_DIV_BIT: begin
        if (div_done) begin
          bit_nxt   = BW'(div_rem);
          div_start = 1'b1;
          state_nxt = ST_DIV_SEG;
        end
      end

      ST_DIV_SEG: begin
        if (div_done) begin
          rd_addr   = SW'(div_rem);
          seg_nxt   = SW'(div_rem);
          state_nxt = ST_RMW;
        end
      end

      ST_RMW: begin
        we = 1'b1;
        if (act_r == ACT_OCCUPY) begin
          wd       = q_r | (SEGMENT_BITS'(1) << bit_r);
          hint_nxt = (hint_bit == BW'(SEGMENT_BITS - 1)) ? seg_inc : seg_r;
        end else begin
          wd = q_r & ~(SEGMENT_BITS'(1) << bit_r);
        end
        out_valid_nxt       = 1'b1;
        out_rsp_nxt.found   = 1'b1;
        out_rsp_nxt.free_id = '0;
        state_nxt           = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      seg_r       <= '0;
      cnt_r       <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      cnt_r       <= cnt_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r     <= act_nxt;
    bit_r     <= bit_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // segment memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[seg_r] <= wd;
    end
    q_r <= mem[rd_addr];
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: src/tiba_div.sv
// Constant divider by reciprocal multiplication, shared by both id-split steps.
// Divides a 16-bit value by DIV_A or DIV_B; depends on tiba_pkg (ID_W).
module tiba_div #(
  parameter int DIV_A = tiba_pkg::SEGMENT_BITS_DEF,
  parameter int DIV_B = tiba_pkg::SEGMENT_COUNT_DEF,
  parameter int DVW   = 17
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      sel_b,
  input  logic [tiba_pkg::ID_W-1:0] dividend,
  output logic                      done,
  output logic [tiba_pkg::ID_W-1:0] quot,
  output logic [DVW-1:0]            rem
);
  import tiba_pkg::*;

  localparam int RW   = ID_W + 1;
  localparam int PW   = ID_W + RW;
  localparam int SH_A = ID_W + $clog2(DIV_A);
  localparam int SH_B = ID_W + $clog2(DIV_B);
  // ceil(2^SH / D) gives the exact quotient for every ID_W-bit dividend
  localparam longint unsigned REC_A = ((64'd1 << SH_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A);
  localparam longint unsigned REC_B = ((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);

  logic            mul_r, mul_nxt;     // quotient step
  logic            sub_r, sub_nxt;     // remainder step
  logic            done_r, done_nxt;
  logic            sel_r, sel_nxt;
  logic [ID_W-1:0] dvd_r, dvd_nxt;
  logic [ID_W-1:0] quo_r, quo_nxt;
  logic [DVW-1:0]  rem_r, rem_nxt;
  logic [RW-1:0]   recip;
  logic [PW-1:0]   prod;
  logic [PW-1:0]   back;

  assign recip = sel_r ? RW'(REC_B) : RW'(REC_A);
  assign prod  = PW'(dvd_r) * PW'(recip);
  assign back  = sel_r ? PW'(quo_r) * PW'(DIV_B) : PW'(quo_r) * PW'(DIV_A);

  always_comb begin
    mul_nxt  = 1'b0;
    sub_nxt  = 1'b0;
    done_nxt = 1'b0;
    sel_nxt  = sel_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      mul_nxt = 1'b1;
      sel_nxt = sel_b;
      dvd_nxt = dividend;
    end else if (mul_r) begin
      quo_nxt = sel_r ? ID_W'(prod >> SH_B) : ID_W'(prod >> SH_A);
      sub_nxt = 1'b1;
    end else if (sub_r) begin
      // remainder stays below the divisor, so DVW bits hold it
      rem_nxt  = DVW'(PW'(dvd_r) - back);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      sub_r  <= sub_nxt;
      done_r <= done_nxt;
    end
    sel_r <= sel_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// File: src/tiba_ffz.sv
// Find-first-zero over one occupancy segment: lowest clear bit and a hit flag.
// Depends on tiba_pkg only by convention; no types used.
module tiba_ffz #(
  parameter int W = 16
) (
  input  logic [W-1:0]         word,
  output logic                 any_zero,
  output logic [$clog2(W)-1:0] idx
);
  import tiba_pkg::*;

  localparam int IW = $clog2(W);

  logic [W-1:0] inv;
  logic [W-1:0] iso;

  assign inv      = ~word;
  assign iso      = inv & (~inv + W'(1));  // isolate lowest set bit of inv
  assign any_zero = |inv;

  always_comb begin
    idx = '0;
    for (int i = 0; i < W; i++) begin
      if (iso[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

// File: src/tiba_checker.sv
// Port-level checker for the allocator, bound to the top level below.
// Depends on tiba_pkg and transaction_id_bitmap_allocator_macros.svh.
`include "transaction_id_bitmap_allocator_macros.svh"

module tiba_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input tiba_pkg::rsp_t out_rsp
);
  import tiba_pkg::*;

  // the clearing sweep holds requests off right after reset
  `TIBA_ASSERT_NOW(a_busy_after_reset, clk, rst_n, $rose(rst_n), busy, "not busy after reset")

  // every accepted request starts work
  `TIBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request did not set busy")

  // the result strobe comes as the block returns to idle
  `TIBA_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")

  `TIBA_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe repeated")

  `TIBA_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_rsp.found, out_rsp.free_id == '0, "miss with nonzero id")

endmodule

bind transaction_id_bitmap_allocator tiba_checker u_tiba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

// File: test/transaction_id_bitmap_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench for transaction_id_bitmap_allocator: directed and random requests.
// Depends on tiba_pkg and the allocator RTL; a shadow id map predicts every result.
module transaction_id_bitmap_allocator_tb;
  import tiba_pkg::*;

  localparam int SEGS      = SEGMENT_COUNT_DEF;
  localparam int SEG_W     = SEGMENT_BITS_DEF;
  localparam int LIMIT     = 2_000_000;
  localparam int DRAIN     = SEGMENT_COUNT_DEF + 100;
  localparam int RAND_REQS = 542;

  // Shadow of the occupancy map and hint; queues the grant each request should produce.
  class id_ledger;
    bit [SEG_W-1:0] used_bits [SEGS];
    bit [ID_W-1:0]  next_hint;
    rsp_t           grants_due [$];
    int             errors;
    int             compared;

    // next-fit: start at the hint's segment, lowest clear bit of first non-full segment
    function bit search_free(output bit [ID_W-1:0] id);
      int seg;
      seg = int'(next_hint) / SEG_W;
      id = '0;
      for (int n = 0; n < SEGS; n++) begin
        if (used_bits[seg] != {SEG_W{1'b1}}) begin
          for (int b = 0; b < SEG_W; b++) begin
            if (!used_bits[seg][b]) begin
              id = ID_W'(seg * SEG_W + b);
              return 1'b1;
            end
          end
        end
        seg = (seg + 1) % SEGS;
      end
      return 1'b0;
    endfunction

    function rsp_t take_request(req_t r);
      rsp_t          g;
      bit [ID_W-1:0] id;
      bit            hit;
      g = '0;
      case (r.action)
        ACT_PEEK: begin
          hit = search_free(id);
          g.found = hit;
          g.free_id = hit ? id : '0;
        end
        ACT_ALLOCATE: begin
          hit = search_free(id);
          if (hit) begin
            used_bits[id / SEG_W][id % SEG_W] = 1'b1;
            next_hint = id + 16'd1;
            g.found = 1'b1;
            g.free_id = id;
          end
        end
        ACT_OCCUPY: begin
          used_bits[r.given_id / SEG_W][r.given_id % SEG_W] = 1'b1;
          next_hint = r.given_id + 16'd1;
          g.found = 1'b1;
        end
        default: begin
          used_bits[r.given_id / SEG_W][r.given_id % SEG_W] = 1'b0;
          g.found = 1'b1;
        end
      endcase
      grants_due.push_back(g);
      return g;
    endfunction

    function void match_grant(rsp_t got);
      rsp_t want;
      if (grants_due.size() == 0) begin
        $error("result with no request pending: found %0d free_id 0x%h",
               got.found, got.free_id);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      compared++;
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.free_id !== want.free_id) begin
        $error("free_id: expected 0x%h, actual 0x%h", want.free_id, got.free_id);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n  = 1'b0;
  logic start  = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_valid;
  rsp_t out_rsp;

  id_ledger      ledger;
  int            cycles;
  int            requests;
  int            random_reqs;
  int            sender_idle_pct;
  rsp_t          last_grant;
  bit [ID_W-1:0] held_ids [$];

  transaction_id_bitmap_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ledger.match_grant(out_rsp);
    end
  end

  // Optional idle cycles, then hold the request until start && !busy at an edge.
  task automatic issue(action_t a, logic [ID_W-1:0] id);
    req_t r;
    r.action = a;
    r.given_id = id;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_grant = ledger.take_request(r);
    requests++;
    if (a == ACT_ALLOCATE && last_grant.found) begin
      held_ids.push_back(last_grant.free_id);
    end else if (a == ACT_OCCUPY) begin
      held_ids.push_back(id);
    end
  endtask

  task automatic random_request();
    int               pick;
    int               idx;
    logic [ID_W-1:0]  id;
    pick = $urandom_range(99);
    id = ID_W'($urandom_range(0, 16'hFFFF));
    if (pick < 35) begin
      issue(ACT_ALLOCATE, id);
    end else if (pick < 45) begin
      issue(ACT_PEEK, id);
    end else if (pick < 75) begin
      // mostly give back ids that are really in use
      if (held_ids.size() > 0 && $urandom_range(4) != 0) begin
        idx = $urandom_range(0, held_ids.size() - 1);
        id = held_ids[idx];
        held_ids.delete(idx);
      end
      issue(ACT_RELEASE, id);
    end else begin
      pick = $urandom_range(9);
      if (pick >= 5 && pick < 8) begin
        // just ahead of the hint, so later searches meet full segments
        id = ledger.next_hint + 16'($urandom_range(0, 40));
      end else if (pick >= 8 && held_ids.size() > 0) begin
        id = held_ids[$urandom_range(0, held_ids.size() - 1)];
      end
      issue(ACT_OCCUPY, id);
    end
    random_reqs++;
  endtask

  initial begin
    ledger = new;
    sender_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, hole below hint bit, hint wrap, repeats, ignored given_id
    issue(ACT_PEEK,     16'h0000);
    issue(ACT_ALLOCATE, 16'hFFFF);
    issue(ACT_ALLOCATE, 16'h0000);
    issue(ACT_RELEASE,  16'h0000);
    issue(ACT_PEEK,     16'h0000);
    issue(ACT_ALLOCATE, 16'h0000);
    issue(ACT_OCCUPY,   16'hFFFF);
    issue(ACT_PEEK,     16'hFFFF);
    issue(ACT_OCCUPY,   16'hFFFE);
    issue(ACT_ALLOCATE, 16'h0000);
    issue(ACT_OCCUPY,   16'hFFFF);
    issue(ACT_RELEASE,  16'h1234);
    issue(ACT_RELEASE,  16'h1234);
    issue(ACT_OCCUPY,   16'h8000);
    issue(ACT_OCCUPY,   16'h8000);
    issue(ACT_ALLOCATE, 16'hFFFF);
    issue(ACT_RELEASE,  16'h8001);
    issue(ACT_RELEASE,  16'h8000);
    issue(ACT_OCCUPY,   16'h5555);
    issue(ACT_OCCUPY,   16'hAAAA);
    issue(ACT_RELEASE,  16'h5555);
    issue(ACT_RELEASE,  16'hAAAA);
    issue(ACT_PEEK,     16'hAAAA);

    // random: light sender gaps, heavy gaps, then back to back
    for (int m = 0; m < 3; m++) begin
      sender_idle_pct = (m == 0) ? 10 : (m == 1) ? 81 : 0;
      repeat (RAND_REQS) random_request();
    end
    start <= 1'b0;

    while (ledger.grants_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (ledger.grants_due.size() != 0) begin
      $error("%0d results never arrived", ledger.grants_due.size());
      ledger.errors++;
    end

    $display("%0d requests sent (%0d random, sender gaps of 10%%, 81%% and none)",
             requests, random_reqs);
    $display("%0d results compared, %0d mismatches", ledger.compared, ledger.errors);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/tiba_pkg.sv
src/tiba_div.sv
src/tiba_ffz.sv
src/transaction_id_bitmap_allocator.sv
src/tiba_checker.sv
test/transaction_id_bitmap_allocator_tb.sv
